>>> rtl/core/acute_seed_node_classifier_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seed node classifier
// Shorthand for clocked implication checks with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef ACUTE_SEED_NODE_CLASSIFIER_TOP_MACROS_SVH
`define ACUTE_SEED_NODE_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication
`define ASNC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/core/asnc_pkg.sv
// ----------------------------------------------------------------------------
// Seed node classifier package
// Shared widths, register indexes and verdict codes.
// ----------------------------------------------------------------------------
package asnc_pkg;

   localparam int ID_BITS        = 20;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = ID_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_A_X       = 3'd0,
      CSR_A_Y       = 3'd1,
      CSR_A_Z       = 3'd2,
      CSR_B_X       = 3'd3,
      CSR_B_Y       = 3'd4,
      CSR_B_Z       = 3'd5,
      CSR_EDGE_ID_A = 3'd6,
      CSR_EDGE_ID_B = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_REJECT    = 3'd0,
      VERDICT_DESCEND   = 3'd1,
      VERDICT_NOT_ACUTE = 3'd2,
      VERDICT_NOT_OWNED = 3'd3,
      VERDICT_SEED      = 3'd4
   } verdict_type;

endpackage

>>> rtl/core/asnc_req_if.sv
// ----------------------------------------------------------------------------
// Seed node classifier request channel
// Valid/ready channel carrying one tree node per request.
// ----------------------------------------------------------------------------
interface asnc_req_if #(
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 20
);
   logic                         valid;
   logic                         ready;
   logic                         is_leaf;
   logic [COORD_BITS-1:0]        low_x;
   logic [COORD_BITS-1:0]        low_y;
   logic [COORD_BITS-1:0]        low_z;
   logic [COORD_BITS-1:0]        high_x;
   logic [COORD_BITS-1:0]        high_y;
   logic [COORD_BITS-1:0]        high_z;
   logic [asnc_pkg::ID_BITS-1:0] point_id;
   logic [INDEX_BITS-1:0]        left_index;
   logic [INDEX_BITS-1:0]        escape_index;

   modport source (
      output valid, is_leaf, low_x, low_y, low_z, high_x, high_y, high_z,
             point_id, left_index, escape_index,
      input  ready
   );

   modport sink (
      input  valid, is_leaf, low_x, low_y, low_z, high_x, high_y, high_z,
             point_id, left_index, escape_index,
      output ready
   );
endinterface

>>> rtl/core/asnc_rsp_if.sv
// ----------------------------------------------------------------------------
// Seed node classifier response channel
// Valid/ready channel carrying one verdict per request.
// ----------------------------------------------------------------------------
interface asnc_rsp_if #(
   parameter int INDEX_BITS = 20
);
   logic                         valid;
   logic                         ready;
   asnc_pkg::verdict_type        verdict;
   logic [INDEX_BITS-1:0]        next_index;
   logic [asnc_pkg::ID_BITS-1:0] seed_id;

   modport source (
      output valid, verdict, next_index, seed_id,
      input  ready
   );

   modport sink (
      input  valid, verdict, next_index, seed_id,
      output ready
   );
endinterface

>>> rtl/core/acute_seed_node_classifier_top.sv
// Classifies one tree node per request against the edge A-B held in the
// configuration registers. The datapath is five register stages (operand
// differences, squares, partial sums, bound and triangle compares, verdict).
// The first stage loads at the edge that accepts a request. A new request is
// accepted every cycle unless the pipeline stalls. Each stage holds its own
// valid bit and stalls only when it is full and the stage after it cannot take
// its request, so backpressure on the response side fills bubbles before it
// stops input. Configuration writes take effect for requests accepted in the
// next cycle.
// ----------------------------------------------------------------------------
// Seed node classifier top level
// Box rejection and acute-leaf ownership test for a fixed edge A-B.
// ----------------------------------------------------------------------------
`include "acute_seed_node_classifier_top_macros.svh"

module acute_seed_node_classifier_top #(
   parameter int COORD_BITS = 16,
   parameter int INDEX_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   asnc_req_if.sink                             req,
   asnc_rsp_if.source                           rsp,
   input  logic                                 csr_we,
   input  logic [asnc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [asnc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int SUM2_W = SQ_W + 1;
   localparam int SUM3_W = SQ_W + 2;
   localparam int MAX_W  = SQ_W + 3;
   localparam int IDW    = asnc_pkg::ID_BITS;
   localparam int STAGES = 5;

   function automatic logic [SQ_W-1:0] square(input logic signed [DIFF_W-1:0] v);
      logic signed [2*DIFF_W-1:0] p;
      p = v * v;
      return p[SQ_W-1:0];
   endfunction

   function automatic logic pair_less(input logic [IDW-1:0] p, input logic [IDW-1:0] q,
                                      input logic [IDW-1:0] r, input logic [IDW-1:0] s);
      logic [IDW-1:0] p0, p1, r0, r1;
      p0 = (p < q) ? p : q;
      p1 = (p < q) ? q : p;
      r0 = (r < s) ? r : s;
      r1 = (r < s) ? s : r;
      return (p0 < r0) || ((p0 == r0) && (p1 < r1));
   endfunction

   // configuration registers
   logic [COORD_BITS-1:0] a_ff [3];
   logic [COORD_BITS-1:0] b_ff [3];
   logic [IDW-1:0]        id_a_ff, id_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= '0;
            b_ff[i] <= '0;
         end
         id_a_ff <= '0;
         id_b_ff <= IDW'(1);
      end else if (csr_we) begin
         case (csr_index)
            asnc_pkg::CSR_A_X:       a_ff[0] <= csr_wdata[COORD_BITS-1:0];
            asnc_pkg::CSR_A_Y:       a_ff[1] <= csr_wdata[COORD_BITS-1:0];
            asnc_pkg::CSR_A_Z:       a_ff[2] <= csr_wdata[COORD_BITS-1:0];
            asnc_pkg::CSR_B_X:       b_ff[0] <= csr_wdata[COORD_BITS-1:0];
            asnc_pkg::CSR_B_Y:       b_ff[1] <= csr_wdata[COORD_BITS-1:0];
            asnc_pkg::CSR_B_Z:       b_ff[2] <= csr_wdata[COORD_BITS-1:0];
            asnc_pkg::CSR_EDGE_ID_A: id_a_ff <= csr_wdata[IDW-1:0];
            asnc_pkg::CSR_EDGE_ID_B: id_b_ff <= csr_wdata[IDW-1:0];
            default: ;
         endcase
      end
   end

   // stage valid bits and per-stage ready
   logic [STAGES-1:0] valid_ff, valid_in, stage_ready;

   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || rsp.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = req.valid;
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req.ready = stage_ready[0];

   // stage 1: differences and nearest-point offsets
   logic [COORD_BITS-1:0]    lo [3];
   logic [COORD_BITS-1:0]    hi [3];
   logic signed [DIFF_W-1:0] al_in [3], ah_in [3], bl_in [3], bh_in [3];
   logic signed [DIFF_W-1:0] na_in [3], nb_in [3], dab_in [3];
   logic signed [DIFF_W-1:0] al_ff [3], ah_ff [3], bl_ff [3], bh_ff [3];
   logic signed [DIFF_W-1:0] na_ff [3], nb_ff [3], dab_ff [3];
   logic                     tie_a_in, tie_b_in;
   logic                     s1_leaf_ff, s1_tie_a_ff, s1_tie_b_ff;
   logic [IDW-1:0]           s1_pid_ff;
   logic [INDEX_BITS-1:0]    s1_left_ff, s1_esc_ff;

   always_comb begin
      lo[0] = req.low_x;
      lo[1] = req.low_y;
      lo[2] = req.low_z;
      hi[0] = req.high_x;
      hi[1] = req.high_y;
      hi[2] = req.high_z;
      for (int i = 0; i < 3; i++) begin
         al_in[i]  = $signed({1'b0, lo[i]}) - $signed({1'b0, a_ff[i]});
         ah_in[i]  = $signed({1'b0, hi[i]}) - $signed({1'b0, a_ff[i]});
         bl_in[i]  = $signed({1'b0, lo[i]}) - $signed({1'b0, b_ff[i]});
         bh_in[i]  = $signed({1'b0, hi[i]}) - $signed({1'b0, b_ff[i]});
         dab_in[i] = $signed({1'b0, a_ff[i]}) - $signed({1'b0, b_ff[i]});
         if (!al_in[i][DIFF_W-1] && (al_in[i] != '0)) begin
            na_in[i] = al_in[i];
         end else if (ah_in[i][DIFF_W-1]) begin
            na_in[i] = ah_in[i];
         end else begin
            na_in[i] = '0;
         end
         if (!bl_in[i][DIFF_W-1] && (bl_in[i] != '0)) begin
            nb_in[i] = bl_in[i];
         end else if (bh_in[i][DIFF_W-1]) begin
            nb_in[i] = bh_in[i];
         end else begin
            nb_in[i] = '0;
         end
      end
      tie_a_in = pair_less(id_a_ff, req.point_id, id_a_ff, id_b_ff);
      tie_b_in = pair_less(id_b_ff, req.point_id, id_a_ff, id_b_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         for (int i = 0; i < 3; i++) begin
            al_ff[i]  <= al_in[i];
            ah_ff[i]  <= ah_in[i];
            bl_ff[i]  <= bl_in[i];
            bh_ff[i]  <= bh_in[i];
            na_ff[i]  <= na_in[i];
            nb_ff[i]  <= nb_in[i];
            dab_ff[i] <= dab_in[i];
         end
         s1_leaf_ff  <= req.is_leaf;
         s1_tie_a_ff <= tie_a_in;
         s1_tie_b_ff <= tie_b_in;
         s1_pid_ff   <= req.point_id;
         s1_left_ff  <= req.left_index;
         s1_esc_ff   <= req.escape_index;
      end
   end

   // stage 2: squares
   logic [SQ_W-1:0]       al2_ff [3], ah2_ff [3], bl2_ff [3], bh2_ff [3];
   logic [SQ_W-1:0]       na2_ff [3], nb2_ff [3], dab2_ff [3];
   logic                  s2_leaf_ff, s2_tie_a_ff, s2_tie_b_ff;
   logic [IDW-1:0]        s2_pid_ff;
   logic [INDEX_BITS-1:0] s2_left_ff, s2_esc_ff;

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         for (int i = 0; i < 3; i++) begin
            al2_ff[i]  <= square(al_ff[i]);
            ah2_ff[i]  <= square(ah_ff[i]);
            bl2_ff[i]  <= square(bl_ff[i]);
            bh2_ff[i]  <= square(bh_ff[i]);
            na2_ff[i]  <= square(na_ff[i]);
            nb2_ff[i]  <= square(nb_ff[i]);
            dab2_ff[i] <= square(dab_ff[i]);
         end
         s2_leaf_ff  <= s1_leaf_ff;
         s2_tie_a_ff <= s1_tie_a_ff;
         s2_tie_b_ff <= s1_tie_b_ff;
         s2_pid_ff   <= s1_pid_ff;
         s2_left_ff  <= s1_left_ff;
         s2_esc_ff   <= s1_esc_ff;
      end
   end

   // stage 3: partial sums
   logic [SUM2_W-1:0]     sl_in [3], sh_in [3], sl_ff [3], sh_ff [3];
   logic [SUM3_W-1:0]     min_a_in, min_b_in, d_in, ax_in, bx_in;
   logic [SUM3_W-1:0]     min_a_ff, min_b_ff, s3_d_ff, ax_ff, bx_ff;
   logic                  s3_leaf_ff, s3_tie_a_ff, s3_tie_b_ff;
   logic [IDW-1:0]        s3_pid_ff;
   logic [INDEX_BITS-1:0] s3_left_ff, s3_esc_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sl_in[i] = SUM2_W'(al2_ff[i]) + SUM2_W'(bl2_ff[i]);
         sh_in[i] = SUM2_W'(ah2_ff[i]) + SUM2_W'(bh2_ff[i]);
      end
      min_a_in = SUM3_W'(na2_ff[0]) + SUM3_W'(na2_ff[1]) + SUM3_W'(na2_ff[2]);
      min_b_in = SUM3_W'(nb2_ff[0]) + SUM3_W'(nb2_ff[1]) + SUM3_W'(nb2_ff[2]);
      d_in     = SUM3_W'(dab2_ff[0]) + SUM3_W'(dab2_ff[1]) + SUM3_W'(dab2_ff[2]);
      ax_in    = SUM3_W'(al2_ff[0]) + SUM3_W'(al2_ff[1]) + SUM3_W'(al2_ff[2]);
      bx_in    = SUM3_W'(bl2_ff[0]) + SUM3_W'(bl2_ff[1]) + SUM3_W'(bl2_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         for (int i = 0; i < 3; i++) begin
            sl_ff[i] <= sl_in[i];
            sh_ff[i] <= sh_in[i];
         end
         min_a_ff    <= min_a_in;
         min_b_ff    <= min_b_in;
         s3_d_ff     <= d_in;
         ax_ff       <= ax_in;
         bx_ff       <= bx_in;
         s3_leaf_ff  <= s2_leaf_ff;
         s3_tie_a_ff <= s2_tie_a_ff;
         s3_tie_b_ff <= s2_tie_b_ff;
         s3_pid_ff   <= s2_pid_ff;
         s3_left_ff  <= s2_left_ff;
         s3_esc_ff   <= s2_esc_ff;
      end
   end

   // stage 4: bound sum and compares
   logic [SUM2_W-1:0]     smax [3];
   logic [MAX_W-1:0]      max_sum_in, max_sum_ff;
   logic                  min_out_in, acute_in, lose_in;
   logic                  min_out_ff, acute_ff, lose_ff;
   logic [SUM3_W-1:0]     s4_d_ff;
   logic                  s4_leaf_ff;
   logic [IDW-1:0]        s4_pid_ff;
   logic [INDEX_BITS-1:0] s4_left_ff, s4_esc_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         smax[i] = (sl_ff[i] > sh_ff[i]) ? sl_ff[i] : sh_ff[i];
      end
      max_sum_in = MAX_W'(smax[0]) + MAX_W'(smax[1]) + MAX_W'(smax[2]);
      min_out_in = (min_a_ff > s3_d_ff) || (min_b_ff > s3_d_ff);
      acute_in   = (MAX_W'(s3_d_ff) + MAX_W'(ax_ff) > MAX_W'(bx_ff))
                && (MAX_W'(s3_d_ff) + MAX_W'(bx_ff) > MAX_W'(ax_ff))
                && (MAX_W'(ax_ff) + MAX_W'(bx_ff) > MAX_W'(s3_d_ff));
      lose_in    = (ax_ff > s3_d_ff) || ((ax_ff == s3_d_ff) && s3_tie_a_ff)
                || (bx_ff > s3_d_ff) || ((bx_ff == s3_d_ff) && s3_tie_b_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         max_sum_ff <= max_sum_in;
         min_out_ff <= min_out_in;
         acute_ff   <= acute_in;
         lose_ff    <= lose_in;
         s4_d_ff    <= s3_d_ff;
         s4_leaf_ff <= s3_leaf_ff;
         s4_pid_ff  <= s3_pid_ff;
         s4_left_ff <= s3_left_ff;
         s4_esc_ff  <= s3_esc_ff;
      end
   end

   // stage 5: verdict and output register
   asnc_pkg::verdict_type verdict_in, verdict_ff;
   logic [INDEX_BITS-1:0] next_in, next_ff;
   logic [IDW-1:0]        seed_in, seed_ff;

   always_comb begin
      seed_in = '0;
      next_in = s4_esc_ff;
      if (s4_leaf_ff) begin
         if (!acute_ff) begin
            verdict_in = asnc_pkg::VERDICT_NOT_ACUTE;
         end else if (lose_ff) begin
            verdict_in = asnc_pkg::VERDICT_NOT_OWNED;
         end else begin
            verdict_in = asnc_pkg::VERDICT_SEED;
            seed_in    = s4_pid_ff;
         end
      end else if (min_out_ff || (max_sum_ff <= MAX_W'(s4_d_ff))) begin
         verdict_in = asnc_pkg::VERDICT_REJECT;
      end else begin
         verdict_in = asnc_pkg::VERDICT_DESCEND;
         next_in    = s4_left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         verdict_ff <= verdict_in;
         next_ff    <= next_in;
         seed_ff    <= seed_in;
      end
   end

   assign rsp.valid      = valid_ff[STAGES-1];
   assign rsp.verdict    = verdict_ff;
   assign rsp.next_index = next_ff;
   assign rsp.seed_id    = seed_ff;

   `ASNC_ASSERT_IMPL(a_seed_id_zero, clock, reset,
      rsp.valid && (rsp.verdict != asnc_pkg::VERDICT_SEED), rsp.seed_id == '0)
   `ASNC_ASSERT_NEXT(a_accept_fills_first, clock, reset,
      req.valid && req.ready, valid_ff[0])
   `ASNC_ASSERT_IMPL(a_full_stall_blocks, clock, reset,
      (&valid_ff) && !rsp.ready, !req.ready)
   `ASNC_ASSERT_NEXT(a_stalled_stage_kept, clock, reset,
      valid_ff[3] && valid_ff[4] && !rsp.ready, valid_ff[3] && valid_ff[4])

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Seed node classifier testbench
// Feeds box and leaf nodes through the classifier under random request and
// response stalls, predicts each verdict from a private copy of the edge
// registers, and compares every response in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 400000;

   typedef struct packed {
      logic        is_leaf;
      logic [15:0] low_x;
      logic [15:0] low_y;
      logic [15:0] low_z;
      logic [15:0] high_x;
      logic [15:0] high_y;
      logic [15:0] high_z;
      logic [19:0] point_id;
      logic [19:0] left_index;
      logic [19:0] escape_index;
   } node_type;

   typedef struct packed {
      asnc_pkg::verdict_type verdict;
      logic [19:0]           next_index;
      logic [19:0]           seed_id;
   } outcome_type;

   class verdict_scoreboard;
      longint      edge_a [3];
      longint      edge_b [3];
      logic [19:0] id_a;
      logic [19:0] id_b;
      outcome_type pending_verdicts [$];
      int          mismatches;

      function new();
         for (int k = 0; k < 3; k++) begin
            edge_a[k] = 0;
            edge_b[k] = 0;
         end
         id_a = '0;
         id_b = 20'd1;
         mismatches = 0;
      endfunction

      function void set_register(asnc_pkg::csr_index_type idx, logic [19:0] value);
         case (idx)
            asnc_pkg::CSR_A_X:       edge_a[0] = longint'(value[15:0]);
            asnc_pkg::CSR_A_Y:       edge_a[1] = longint'(value[15:0]);
            asnc_pkg::CSR_A_Z:       edge_a[2] = longint'(value[15:0]);
            asnc_pkg::CSR_B_X:       edge_b[0] = longint'(value[15:0]);
            asnc_pkg::CSR_B_Y:       edge_b[1] = longint'(value[15:0]);
            asnc_pkg::CSR_B_Z:       edge_b[2] = longint'(value[15:0]);
            asnc_pkg::CSR_EDGE_ID_A: id_a = value;
            asnc_pkg::CSR_EDGE_ID_B: id_b = value;
            default: ;
         endcase
      endfunction

      function bit pair_below(logic [19:0] p, logic [19:0] q, logic [19:0] r, logic [19:0] s);
         logic [19:0] p0, p1, r0, r1;
         p0 = (p < q) ? p : q;
         p1 = (p < q) ? q : p;
         r0 = (r < s) ? r : s;
         r1 = (r < s) ? s : r;
         return (p0 < r0) || (p0 == r0 && p1 < r1);
      endfunction

      function outcome_type classify_node(node_type n);
         longint      lo [3];
         longint      hi [3];
         longint      d, da, db, min_a, min_b, max_sum;
         longint      al, ah, bl, bh, na, nb, sl, sh;
         bit          acute, lose_a, lose_b;
         outcome_type r;
         lo[0] = longint'(n.low_x);
         lo[1] = longint'(n.low_y);
         lo[2] = longint'(n.low_z);
         hi[0] = longint'(n.high_x);
         hi[1] = longint'(n.high_y);
         hi[2] = longint'(n.high_z);
         d = 0;
         da = 0;
         db = 0;
         min_a = 0;
         min_b = 0;
         max_sum = 0;
         for (int k = 0; k < 3; k++) begin
            d  += (edge_a[k] - edge_b[k]) * (edge_a[k] - edge_b[k]);
            da += (edge_a[k] - lo[k]) * (edge_a[k] - lo[k]);
            db += (edge_b[k] - lo[k]) * (edge_b[k] - lo[k]);
            al = lo[k] - edge_a[k];
            ah = hi[k] - edge_a[k];
            bl = lo[k] - edge_b[k];
            bh = hi[k] - edge_b[k];
            na = (al > 0) ? al : ((ah < 0) ? ah : 0);
            nb = (bl > 0) ? bl : ((bh < 0) ? bh : 0);
            sl = al * al + bl * bl;
            sh = ah * ah + bh * bh;
            min_a += na * na;
            min_b += nb * nb;
            max_sum += (sl > sh) ? sl : sh;
         end
         r.seed_id = '0;
         r.next_index = n.escape_index;
         if (n.is_leaf) begin
            acute = (d + da > db) && (d + db > da) && (da + db > d);
            lose_a = (da > d) || (da == d && pair_below(id_a, n.point_id, id_a, id_b));
            lose_b = (db > d) || (db == d && pair_below(id_b, n.point_id, id_a, id_b));
            if (!acute) begin
               r.verdict = asnc_pkg::VERDICT_NOT_ACUTE;
            end else if (lose_a || lose_b) begin
               r.verdict = asnc_pkg::VERDICT_NOT_OWNED;
            end else begin
               r.verdict = asnc_pkg::VERDICT_SEED;
               r.seed_id = n.point_id;
            end
         end else if (min_a > d || min_b > d || max_sum <= d) begin
            r.verdict = asnc_pkg::VERDICT_REJECT;
         end else begin
            r.verdict = asnc_pkg::VERDICT_DESCEND;
            r.next_index = n.left_index;
         end
         return r;
      endfunction

      function void note_node(node_type n);
         pending_verdicts.insert(pending_verdicts.size(), classify_node(n));
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_verdict(outcome_type got);
         outcome_type want;
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("response with no request outstanding, verdict %0d",
                                      got.verdict));
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
         if (got.next_index !== want.next_index)
            report_mismatch($sformatf("next_index %h, want %h",
                                      got.next_index, want.next_index));
         if (got.seed_id !== want.seed_id)
            report_mismatch($sformatf("seed_id %h, want %h", got.seed_id, want.seed_id));
      endtask
   endclass

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic [asnc_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [asnc_pkg::CSR_DATA_BITS-1:0]  csr_wdata;
   int                                  send_idle = 0;
   int                                  rcv_idle = 0;
   int                                  cycles = 0;
   verdict_scoreboard                   sb = new();

   asnc_req_if #(.COORD_BITS(16), .INDEX_BITS(20)) req ();
   asnc_rsp_if #(.INDEX_BITS(20)) rsp ();

   acute_seed_node_classifier_top #(
      .COORD_BITS (16),
      .INDEX_BITS (20)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp.ready <= (int'($urandom_range(99)) >= rcv_idle);
   end

   always @(posedge clock) begin
      node_type    seen;
      outcome_type got;
      if (!reset) begin
         if (req.valid && req.ready) begin
            seen.is_leaf      = req.is_leaf;
            seen.low_x        = req.low_x;
            seen.low_y        = req.low_y;
            seen.low_z        = req.low_z;
            seen.high_x       = req.high_x;
            seen.high_y       = req.high_y;
            seen.high_z       = req.high_z;
            seen.point_id     = req.point_id;
            seen.left_index   = req.left_index;
            seen.escape_index = req.escape_index;
            sb.note_node(seen);
         end
         if (rsp.valid && rsp.ready) begin
            got.verdict    = rsp.verdict;
            got.next_index = rsp.next_index;
            got.seed_id    = rsp.seed_id;
            sb.check_verdict(got);
         end
      end
   end

   function automatic logic [15:0] coord(int v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hFFFF;
      return v[15:0];
   endfunction

   function automatic node_type node_of(bit leaf, int lx, int ly, int lz,
                                        int hx, int hy, int hz, logic [19:0] pid);
      node_type n;
      n.is_leaf      = leaf;
      n.low_x        = coord(lx);
      n.low_y        = coord(ly);
      n.low_z        = coord(lz);
      n.high_x       = coord(hx);
      n.high_y       = coord(hy);
      n.high_z       = coord(hz);
      n.point_id     = pid;
      n.left_index   = 20'($urandom);
      n.escape_index = 20'($urandom);
      return n;
   endfunction

   function automatic node_type random_node();
      int          a [3], b [3], lo [3], hi [3], v [3], w [3];
      int          span, gap, pick, sel, rot, mid, c, tmp, flip;
      logic [19:0] pid;
      span = 1;
      for (int k = 0; k < 3; k++) begin
         a[k] = int'(sb.edge_a[k]);
         b[k] = int'(sb.edge_b[k]);
         gap = (a[k] > b[k]) ? a[k] - b[k] : b[k] - a[k];
         if (gap + 1 > span) span = gap + 1;
      end
      pick = $urandom_range(99);
      sel = $urandom_range(1);
      pid = 20'($urandom);
      if ($urandom_range(1)) begin
         rot = $urandom_range(2);
         for (int k = 0; k < 3; k++) v[k] = sel ? a[k] - b[k] : b[k] - a[k];
         for (int k = 0; k < 3; k++) w[k] = v[(k + rot) % 3];
         if ($urandom_range(1)) begin
            tmp = w[0];
            w[0] = w[1];
            w[1] = tmp;
         end
         flip = $urandom_range(3);
         if (flip < 3) w[flip] = -w[flip];
         for (int k = 0; k < 3; k++) begin
            mid = (a[k] + b[k]) / 2;
            hi[k] = $urandom_range(65535);
            if (pick < 15) lo[k] = $urandom_range(65535);
            else if (pick < 55) lo[k] = mid + int'($urandom_range(2 * span)) - span;
            else if (pick < 65) lo[k] = sel ? a[k] : b[k];
            else if (pick < 85) lo[k] = (sel ? b[k] : a[k]) + w[k];
            else lo[k] = sel ? 2 * a[k] - b[k] : 2 * b[k] - a[k];
         end
         case ($urandom_range(7))
            0: pid = sb.id_a;
            1: pid = sb.id_b;
            2: pid = sb.id_a + 20'd1;
            3: pid = sb.id_a - 20'd1;
            4: pid = sb.id_b + 20'd1;
            5: pid = sb.id_b - 20'd1;
            6: pid = 20'($urandom_range(3));
            default: ;
         endcase
         return node_of(1'b1, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], pid);
      end
      for (int k = 0; k < 3; k++) begin
         mid = (a[k] + b[k]) / 2;
         if (pick < 25) begin
            lo[k] = $urandom_range(65535);
            hi[k] = $urandom_range(65535);
         end else if (pick < 65) begin
            c = mid + int'($urandom_range(2 * span)) - span;
            lo[k] = c - int'($urandom_range(span));
            hi[k] = c + int'($urandom_range(span));
         end else if (pick < 75) begin
            lo[k] = ((a[k] < b[k]) ? a[k] : b[k]) - int'($urandom_range(span));
            hi[k] = ((a[k] < b[k]) ? b[k] : a[k]) + int'($urandom_range(span));
         end else if (pick < 85) begin
            lo[k] = mid - int'($urandom_range(2));
            hi[k] = mid + int'($urandom_range(2));
         end else begin
            c = sel ? a[k] : b[k];
            lo[k] = c - int'($urandom_range(span / 4));
            hi[k] = c + int'($urandom_range(span / 4));
         end
      end
      return node_of(1'b0, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], pid);
   endfunction

   task automatic send_node(node_type n);
      while (int'($urandom_range(99)) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.is_leaf      <= n.is_leaf;
      req.low_x        <= n.low_x;
      req.low_y        <= n.low_y;
      req.low_z        <= n.low_z;
      req.high_x       <= n.high_x;
      req.high_y       <= n.high_y;
      req.high_z       <= n.high_z;
      req.point_id     <= n.point_id;
      req.left_index   <= n.left_index;
      req.escape_index <= n.escape_index;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // hold off requests until every outstanding verdict has come back
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_edge(input logic [15:0] ax, ay, az, bx, by, bz,
                             input logic [19:0] ida, idb, input logic [7:0] mask);
      logic [19:0]             vals [8];
      logic [3:0]              junk;
      asnc_pkg::csr_index_type idx;
      junk = 4'($urandom);
      vals[0] = {junk, ax};
      vals[1] = {junk, ay};
      vals[2] = {junk, az};
      vals[3] = {junk, bx};
      vals[4] = {junk, by};
      vals[5] = {junk, bz};
      vals[6] = ida;
      vals[7] = idb;
      for (int i = 0; i < 8; i++) begin
         if (mask[i]) begin
            idx = asnc_pkg::csr_index_type'(i);
            csr_we    <= 1'b1;
            csr_index <= idx;
            csr_wdata <= vals[i];
            sb.set_register(idx, vals[i]);
            @(posedge clock);
         end
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      node_type    n;
      int          cm, im;
      int          ea [3], eb [3];
      logic [19:0] ida, idb;
      logic [7:0]  mask;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= asnc_pkg::CSR_A_X;
      csr_wdata        <= '0;
      req.valid        <= 1'b0;
      req.is_leaf      <= 1'b0;
      req.low_x        <= '0;
      req.low_y        <= '0;
      req.low_z        <= '0;
      req.high_x       <= '0;
      req.high_y       <= '0;
      req.high_z       <= '0;
      req.point_id     <= '0;
      req.left_index   <= '0;
      req.escape_index <= '0;
      send_idle = 35;
      rcv_idle = 57;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // zero-length edge out of reset
      send_node(node_of(1'b1, 0, 0, 0, 0, 0, 0, 20'd7));
      send_node(node_of(1'b0, 0, 0, 0, 0, 0, 0, 20'd7));
      drain();

      write_edge(16'd1000, 16'd1000, 16'd1000, 16'd1300, 16'd1400, 16'd1000,
                 20'd10, 20'd20, 8'hFF);
      send_node(node_of(1'b1, 1150, 1200, 1000, 0, 0, 0, 20'd99));
      send_node(node_of(1'b1, 1150, 1200, 1300, 0, 0, 0, 20'd99));
      send_node(node_of(1'b1, 1000, 1000, 1000, 0, 0, 0, 20'd99));
      send_node(node_of(1'b1, 1300, 1400, 1000, 0, 0, 0, 20'd99));
      // AP as long as AB: id pair decides
      send_node(node_of(1'b1, 1500, 1000, 1000, 0, 0, 0, 20'd5));
      send_node(node_of(1'b1, 1500, 1000, 1000, 0, 0, 0, 20'd30));
      send_node(node_of(1'b1, 1500, 1000, 1000, 0, 0, 0, 20'd20));
      // BP as long as AB
      send_node(node_of(1'b1, 1300, 900, 1000, 0, 0, 0, 20'd5));
      send_node(node_of(1'b1, 1300, 900, 1000, 0, 0, 0, 20'd25));
      send_node(node_of(1'b1, 1150, 1200, 1700, 0, 0, 0, 20'd3));
      n = node_of(1'b0, 0, 0, 0, 65535, 65535, 65535, 20'd0);
      n.left_index = '1;
      n.escape_index = '0;
      send_node(n);
      send_node(node_of(1'b0, 65535, 65535, 65535, 0, 0, 0, 20'd0));
      send_node(node_of(1'b0, 1150, 1200, 1000, 1150, 1200, 1000, 20'd0));
      send_node(node_of(1'b0, 60000, 60000, 60000, 65535, 65535, 65535, 20'd0));
      send_node(node_of(1'b0, 1290, 1390, 990, 1310, 1410, 1010, 20'd0));
      n = node_of(1'b1, 65535, 65535, 65535, 65535, 65535, 65535, 20'hFFFFF);
      n.left_index = '0;
      n.escape_index = '1;
      send_node(n);
      n = node_of(1'b1, 0, 0, 0, 0, 0, 0, 20'd0);
      n.left_index = '1;
      n.escape_index = '0;
      send_node(n);
      drain();

      write_edge(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 20'hFFFFF, 20'hFFFFE, 8'hFF);
      send_node(node_of(1'b1, 0, 65535, 0, 0, 0, 0, 20'd0));
      send_node(node_of(1'b1, 65535, 0, 32768, 0, 0, 0, 20'hFFFFF));
      send_node(node_of(1'b0, 32767, 32767, 32767, 32768, 32768, 32768, 20'd0));
      drain();

      write_edge(16'd40000, 16'd123, 16'hFFFF, 16'd40000, 16'd123, 16'hFFFF,
                 20'd5, 20'd5, 8'hFF);
      send_node(node_of(1'b1, 40000, 123, 65535, 0, 0, 0, 20'd5));
      send_node(node_of(1'b0, 40000, 123, 65535, 40000, 123, 65535, 20'd0));
      send_node(node_of(1'b0, 39990, 113, 65525, 40010, 133, 65535, 20'd0));

      for (int blk = 0; blk < 23; blk++) begin
         if (blk < 8) begin
            send_idle = 35;
            rcv_idle = 57;
         end else if (blk < 16) begin
            send_idle = 57;
            rcv_idle = 35;
         end else begin
            send_idle = 0;
            rcv_idle = 0;
         end
         drain();
         cm = $urandom_range(9);
         for (int k = 0; k < 3; k++) begin
            ea[k] = $urandom_range(65535);
            eb[k] = $urandom_range(65535);
            if (cm >= 4 && cm <= 6) eb[k] = ea[k] + int'($urandom_range(600)) - 300;
            if (cm == 7) begin
               ea[k] = $urandom_range(1) ? 65535 : 0;
               eb[k] = $urandom_range(1) ? 65535 : 0;
            end
            if (cm == 8) eb[k] = ea[k];
         end
         im = $urandom_range(3);
         ida = 20'($urandom);
         idb = 20'($urandom);
         if (im == 1) begin
            ida = 20'($urandom_range(3));
            idb = 20'($urandom_range(3));
         end else if (im == 2) begin
            ida = 20'hFFFFF;
            idb = 20'hFFFFE;
         end else if (im == 3) begin
            idb = ida;
         end
         mask = 8'($urandom);
         if (cm != 9) mask = 8'hFF;
         write_edge(coord(ea[0]), coord(ea[1]), coord(ea[2]),
                    coord(eb[0]), coord(eb[1]), coord(eb[2]), ida, idb, mask);
         repeat (50) send_node(random_node());
      end

      drain();
      if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
